>>> hw/rtl/che_pkg.sv
// Shared types, constants and helper functions of the chained hash table engine.
package che_pkg;

    localparam int ENTRIES     = 64;
    localparam int ENTRY_W     = $clog2(ENTRIES);
    localparam int BUCKETS     = 64;
    localparam int BKT_W       = $clog2(BUCKETS);
    localparam int KEY_BYTES   = 8;
    localparam int KEY_W       = 8 * KEY_BYTES;
    localparam int LEN_W       = 4;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = 7;
    localparam int STAT_W      = 3;
    localparam int KIND_W      = 2;
    localparam int BC_W        = 7;
    localparam int RES_LIMIT   = 64;
    localparam int GRP_SIZE    = 8;
    localparam int GROUPS      = ENTRIES / GRP_SIZE;
    localparam int GRP_W       = $clog2(GROUPS);
    localparam int SLOT_W      = $clog2(GRP_SIZE);
    localparam int DIGITS      = 32 / 4;
    localparam int DIG_W       = $clog2(DIGITS);

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_FIND   = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_RSVD   = 2'd3
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_TOO_LONG = 3'd1,
        ST_FULL     = 3'd2,
        ST_BAD_HDL  = 3'd3,
        ST_NO_MATCH = 3'd4
    } t_status;

    // Result kinds the datapath can load into the output register
    typedef enum logic [2:0] {
        OS_LONG      = 3'd0,
        OS_FULL      = 3'd1,
        OS_INS_OK    = 3'd2,
        OS_BAD_HDL   = 3'd3,
        OS_DEL_OK    = 3'd4,
        OS_NO_MATCH  = 3'd5,
        OS_PEND_MID  = 3'd6,
        OS_PEND_LAST = 3'd7
    } t_out_sel;

    typedef enum logic [1:0] {
        ENT_HANDLE = 2'd0,
        ENT_HEAD   = 2'd1,
        ENT_NEXT   = 2'd2
    } t_ent_src;

    typedef enum logic {
        BKT_HASH = 1'b0,
        BKT_REC  = 1'b1
    } t_bkt_src;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
        logic [BKT_W-1:0]  bucket;
    } t_rec;

    typedef struct packed {
        logic [ENTRY_W-1:0] head;
        logic [ENTRY_W-1:0] tail;
    } t_bkt;

    // Commands from controller to datapath
    typedef struct packed {
        logic     capture;
        logic     hash_start;
        logic     scan_start;
        logic     bkt_rd;
        t_bkt_src bkt_src;
        logic     ent_rd;
        t_ent_src ent_src;
        logic     ins_wr1;
        logic     ins_wr2;
        logic     del_wr;
        logic     fnd_take;
        logic     out_load;
        t_out_sel out_sel;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic too_long;
        logic find_skip;
        logic del_invalid;
        logic hash_done;
        logic scan_busy;
        logic free_found;
        logic bkt_nonempty;
        logic match;
        logic is_tail;
        logic hit_limit;
        logic pend_valid;
        logic out_free;
    } t_sts;

    function automatic logic [KEY_W-1:0] key_mask(input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] m;
        if (len >= LEN_W'(KEY_BYTES)) begin
            m = '1;
        end else begin
            m = (KEY_W'(1) << {len, 3'b000}) - KEY_W'(1);
        end
        return m;
    endfunction

    // One addend of the additive hash; len is at most KEY_BYTES here
    function automatic logic [31:0] hash_term(input logic [KEY_W-1:0] key,
                                              input logic [LEN_W-1:0] len,
                                              input logic [1:0]       idx);
        logic [3:0]       pos;
        logic [KEY_W-1:0] sh;
        logic [31:0]      t;
        t   = '0;
        pos = 4'd0;
        case (idx)
            2'd0: pos = 4'd0;
            2'd1: pos = {3'b000, len[0]};
            2'd2: pos = {3'b000, len[0]} + {2'b00, len[1], 1'b0};
            default: pos = {3'b000, len[0]} + {2'b00, len[1], 1'b0} + 4'd4;
        endcase
        sh = key >> {pos, 3'b000};
        case (idx)
            2'd0: t = len[0] ? {24'd0, sh[7:0]} : 32'd0;
            2'd1: t = len[1] ? {16'd0, sh[15:0]} : 32'd0;
            2'd2: t = (len[3] | len[2]) ? sh[31:0] : 32'd0;
            default: t = len[3] ? sh[31:0] : 32'd0;
        endcase
        return t;
    endfunction

    function automatic logic [SLOT_W-1:0] lowest_zero(input logic [GRP_SIZE-1:0] v);
        logic [SLOT_W-1:0] s;
        s = '0;
        for (int i = GRP_SIZE - 1; i >= 0; i--) begin
            if (!v[i]) begin
                s = SLOT_W'(i);
            end
        end
        return s;
    endfunction

endpackage

>>> hw/rtl/che_hash.sv
// Additive key hash followed by a nibble-serial modulo by the bucket count.
module che_hash (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [che_pkg::KEY_W-1:0] i_key,
    input  logic [che_pkg::LEN_W-1:0] i_len,
    input  logic [che_pkg::BC_W-1:0]  i_bucket_count,
    output logic                      o_done,
    output logic [che_pkg::BKT_W-1:0] o_bucket
);
    import che_pkg::*;

    typedef enum logic [2:0] {
        H_IDLE = 3'b001,
        H_SUM  = 3'b010,
        H_MOD  = 3'b100
    } t_hash_state;

    t_hash_state       r_state;
    logic [1:0]        r_idx;
    logic [DIG_W-1:0]  r_dig;
    logic [31:0]       r_sum;
    logic [BC_W-1:0]   r_rem;
    logic              r_done;
    logic [BC_W-1:0]   n_rem;

    // Four restoring steps per cycle on the top nibble of the sum
    always_comb begin
        logic [BC_W-1:0] t;
        t = r_rem;
        for (int i = 3; i >= 0; i--) begin
            t = {t[BC_W-2:0], r_sum[28 + i]};
            if (t >= i_bucket_count) begin
                t = t - i_bucket_count;
            end
        end
        n_rem = t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_state <= H_SUM;
                        r_done  <= 1'b0;
                        r_idx   <= '0;
                        r_sum   <= '0;
                    end
                end
                H_SUM: begin
                    r_sum <= r_sum + hash_term(i_key, i_len, r_idx);
                    r_idx <= r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        r_state <= H_MOD;
                        r_rem   <= '0;
                        r_dig   <= '0;
                    end
                end
                H_MOD: begin
                    r_rem <= n_rem;
                    r_sum <= {r_sum[27:0], 4'd0};
                    r_dig <= r_dig + DIG_W'(1);
                    if (r_dig == DIG_W'(DIGITS - 1)) begin
                        r_state <= H_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= H_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_rem[BKT_W-1:0];

endmodule

>>> hw/rtl/che_dp.sv
// Datapath: captured item, entry and bucket memories, free-entry scan and result register.
module che_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  che_pkg::t_cmd              i_cmd,
    output che_pkg::t_sts              o_sts,
    input  logic [che_pkg::KEY_W-1:0]  i_key,
    input  logic [che_pkg::LEN_W-1:0]  i_key_length,
    input  logic [che_pkg::DATA_W-1:0] i_data_value,
    input  logic [che_pkg::ENTRY_W-1:0] i_handle,
    input  logic [che_pkg::CNT_W-1:0]  i_max_matches,
    input  logic [che_pkg::BC_W-1:0]   i_bucket_count,
    input  logic [che_pkg::LEN_W-1:0]  i_key_limit,
    input  logic                       i_m_ready,
    output logic                       o_m_valid,
    output logic [che_pkg::STAT_W-1:0] o_status,
    output logic [che_pkg::ENTRY_W-1:0] o_handle_res,
    output logic [che_pkg::DATA_W-1:0] o_data_value_res,
    output logic [che_pkg::CNT_W-1:0]  o_match_count,
    output logic                       o_last
);
    import che_pkg::*;

    // Captured item
    logic [KEY_W-1:0]   r_key;
    logic [LEN_W-1:0]   r_len;
    logic [DATA_W-1:0]  r_data;
    logic [ENTRY_W-1:0] r_handle;
    logic [CNT_W-1:0]   r_want;

    // Flop-based marks
    logic [ENTRIES-1:0] r_valid;
    logic [BUCKETS-1:0] r_nonempty;

    // Memories and registered read data
    t_rec               m_rec  [ENTRIES];
    logic [ENTRY_W-1:0] m_next [ENTRIES];
    logic [ENTRY_W-1:0] m_prev [ENTRIES];
    t_bkt               m_bkt  [BUCKETS];
    t_rec               r_rd_rec;
    logic [ENTRY_W-1:0] r_rd_next;
    logic [ENTRY_W-1:0] r_rd_prev;
    t_bkt               r_rd_bkt;

    // Free-entry scan
    logic               r_scan_busy;
    logic [GRP_W-1:0]   r_scan_grp;
    logic               r_free_found;
    logic [ENTRY_W-1:0] r_free_idx;

    // Find walk
    logic [ENTRY_W-1:0] r_cur;
    logic [CNT_W-1:0]   r_n;
    logic               r_pend_valid;
    logic [ENTRY_W-1:0] r_pend_hdl;
    logic [DATA_W-1:0]  r_pend_data;
    logic [CNT_W-1:0]   r_pend_cnt;

    // Insert link-up
    logic               r_link_needed;
    logic [ENTRY_W-1:0] r_link_tail;

    // Output register
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_out_status;
    logic [ENTRY_W-1:0] r_out_hdl;
    logic [DATA_W-1:0]  r_out_data;
    logic [CNT_W-1:0]   r_out_cnt;
    logic               r_out_last;

    logic               hash_done;
    logic [BKT_W-1:0]   hash_bucket;
    logic               out_free;
    logic [ENTRY_W-1:0] ent_addr;
    logic [BKT_W-1:0]   bkt_addr;
    logic [GRP_SIZE-1:0] grp_bits;

    che_hash u_hash (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_cmd.hash_start),
        .i_key          (r_key),
        .i_len          (r_len),
        .i_bucket_count (i_bucket_count),
        .o_done         (hash_done),
        .o_bucket       (hash_bucket)
    );

    assign out_free = !r_out_valid || i_m_ready;

    // Capture the item, masking unused key bytes and clamping the match limit
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key    <= i_key & key_mask(i_key_length);
            r_len    <= i_key_length;
            r_data   <= i_data_value;
            r_handle <= i_handle;
            r_want   <= (i_max_matches > CNT_W'(RES_LIMIT)) ? CNT_W'(RES_LIMIT)
                                                             : i_max_matches;
        end
    end

    // Select read addresses
    always_comb begin
        case (i_cmd.ent_src)
            ENT_HEAD: ent_addr = r_rd_bkt.head;
            ENT_NEXT: ent_addr = r_rd_next;
            default:  ent_addr = r_handle;
        endcase
        bkt_addr = (i_cmd.bkt_src == BKT_REC) ? r_rd_rec.bucket : hash_bucket;
    end

    // Delete cases
    logic del_is_head, del_is_tail;
    assign del_is_head = (r_rd_bkt.head == r_handle);
    assign del_is_tail = (r_rd_bkt.tail == r_handle);

    // Write ports of the link and bucket memories
    logic               next_we, prev_we, bkt_we;
    logic [ENTRY_W-1:0] next_wa, next_wd, prev_wa, prev_wd;
    logic [BKT_W-1:0]   bkt_wa;
    t_bkt               bkt_wd;
    logic               was_nonempty;

    assign was_nonempty = r_nonempty[hash_bucket];

    always_comb begin
        next_we = 1'b0; next_wa = r_free_idx; next_wd = r_free_idx;
        prev_we = 1'b0; prev_wa = r_free_idx; prev_wd = r_free_idx;
        bkt_we  = 1'b0; bkt_wa  = hash_bucket;
        bkt_wd  = '{head: r_free_idx, tail: r_free_idx};
        if (i_cmd.ins_wr1) begin
            next_we = 1'b1;
            prev_we = 1'b1;
            prev_wd = was_nonempty ? r_rd_bkt.tail : r_free_idx;
            bkt_we  = 1'b1;
            bkt_wd  = '{head: (was_nonempty ? r_rd_bkt.head : r_free_idx),
                        tail: r_free_idx};
        end else if (i_cmd.ins_wr2) begin
            next_we = r_link_needed;
            next_wa = r_link_tail;
        end else if (i_cmd.del_wr) begin
            bkt_wa = r_rd_rec.bucket;
            if (del_is_head && del_is_tail) begin
                bkt_we = 1'b0;
            end else if (del_is_head) begin
                bkt_we  = 1'b1;
                bkt_wd  = '{head: r_rd_next, tail: r_rd_bkt.tail};
                prev_we = 1'b1;
                prev_wa = r_rd_next;
                prev_wd = r_rd_next;
            end else if (del_is_tail) begin
                bkt_we  = 1'b1;
                bkt_wd  = '{head: r_rd_bkt.head, tail: r_rd_prev};
                next_we = 1'b1;
                next_wa = r_rd_prev;
                next_wd = r_rd_prev;
            end else begin
                next_we = 1'b1;
                next_wa = r_rd_prev;
                next_wd = r_rd_next;
                prev_we = 1'b1;
                prev_wa = r_rd_next;
                prev_wd = r_rd_prev;
            end
        end
    end

    // Entry record memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr1) begin
            m_rec[r_free_idx] <= '{key: r_key, len: r_len, data: r_data,
                                   bucket: hash_bucket};
        end
        if (i_cmd.ent_rd) begin
            r_rd_rec <= m_rec[ent_addr];
        end
    end

    // Next-link memory
    always_ff @(posedge i_clk) begin
        if (next_we) begin
            m_next[next_wa] <= next_wd;
        end
        if (i_cmd.ent_rd) begin
            r_rd_next <= m_next[ent_addr];
        end
    end

    // Prev-link memory
    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            m_prev[prev_wa] <= prev_wd;
        end
        if (i_cmd.ent_rd) begin
            r_rd_prev <= m_prev[ent_addr];
        end
    end

    // Bucket head/tail memory
    always_ff @(posedge i_clk) begin
        if (bkt_we) begin
            m_bkt[bkt_wa] <= bkt_wd;
        end
        if (i_cmd.bkt_rd) begin
            r_rd_bkt <= m_bkt[bkt_addr];
        end
    end

    // Track the walk position
    always_ff @(posedge i_clk) begin
        if (i_cmd.ent_rd) begin
            r_cur <= ent_addr;
        end
        if (i_cmd.ins_wr1) begin
            r_link_needed <= was_nonempty;
            r_link_tail   <= r_rd_bkt.tail;
        end
    end

    // Valid and nonempty marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_nonempty <= '0;
        end else if (i_cmd.ins_wr1) begin
            r_valid[r_free_idx]     <= 1'b1;
            r_nonempty[hash_bucket] <= 1'b1;
        end else if (i_cmd.del_wr) begin
            r_valid[r_handle] <= 1'b0;
            if (del_is_head && del_is_tail) begin
                r_nonempty[r_rd_rec.bucket] <= 1'b0;
            end
        end
    end

    // Scan one group of valid marks per cycle for the lowest free entry
    assign grp_bits = r_valid[r_scan_grp * GRP_SIZE +: GRP_SIZE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_busy  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_scan_busy  <= 1'b1;
            r_free_found <= 1'b0;
            r_scan_grp   <= '0;
        end else if (r_scan_busy) begin
            if (grp_bits != '1) begin
                r_free_found <= 1'b1;
                r_free_idx   <= {r_scan_grp, lowest_zero(grp_bits)};
                r_scan_busy  <= 1'b0;
            end else if (r_scan_grp == GRP_W'(GROUPS - 1)) begin
                r_scan_busy <= 1'b0;
            end else begin
                r_scan_grp <= r_scan_grp + GRP_W'(1);
            end
        end
    end

    // Hold the latest match until it is known whether another follows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.capture) begin
            r_pend_valid <= 1'b0;
            r_n          <= '0;
        end else if (i_cmd.fnd_take) begin
            r_pend_valid <= 1'b1;
            r_pend_hdl   <= r_cur;
            r_pend_data  <= r_rd_rec.data;
            r_pend_cnt   <= r_n + CNT_W'(1);
            r_n          <= r_n + CNT_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid  <= 1'b1;
            r_out_hdl    <= '0;
            r_out_data   <= '0;
            r_out_cnt    <= '0;
            r_out_last   <= 1'b1;
            r_out_status <= ST_OK;
            case (i_cmd.out_sel)
                OS_LONG:     r_out_status <= ST_TOO_LONG;
                OS_FULL:     r_out_status <= ST_FULL;
                OS_INS_OK:   r_out_hdl    <= r_free_idx;
                OS_BAD_HDL: begin
                    r_out_status <= ST_BAD_HDL;
                    r_out_hdl    <= r_handle;
                end
                OS_DEL_OK:   r_out_hdl    <= r_handle;
                OS_NO_MATCH: r_out_status <= ST_NO_MATCH;
                OS_PEND_MID, OS_PEND_LAST: begin
                    r_out_hdl  <= r_pend_hdl;
                    r_out_data <= r_pend_data;
                    r_out_cnt  <= r_pend_cnt;
                    r_out_last <= (i_cmd.out_sel == OS_PEND_LAST);
                end
                default: r_out_status <= ST_OK;
            endcase
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Status to the controller
    assign o_sts.too_long     = (r_len > i_key_limit);
    assign o_sts.find_skip    = (r_len > LEN_W'(KEY_BYTES)) || (r_want == '0);
    assign o_sts.del_invalid  = !r_valid[r_handle];
    assign o_sts.hash_done    = hash_done;
    assign o_sts.scan_busy    = r_scan_busy;
    assign o_sts.free_found   = r_free_found;
    assign o_sts.bkt_nonempty = was_nonempty;
    assign o_sts.match        = r_valid[r_cur] && (r_rd_rec.len == r_len)
                                && (r_rd_rec.key == r_key);
    assign o_sts.is_tail      = (r_cur == r_rd_bkt.tail);
    assign o_sts.hit_limit    = ((r_n + CNT_W'(1)) == r_want);
    assign o_sts.pend_valid   = r_pend_valid;
    assign o_sts.out_free     = out_free;

    assign o_m_valid        = r_out_valid;
    assign o_status         = r_out_status;
    assign o_handle_res     = r_out_hdl;
    assign o_data_value_res = r_out_data;
    assign o_match_count    = r_out_cnt;
    assign o_last           = r_out_last;

endmodule

>>> hw/rtl/che_ctrl.sv
// Controller state machine that sequences insert, find and delete over the datapath.
module che_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_valid,
    input  logic [che_pkg::KIND_W-1:0] i_kind,
    output logic                       o_s_ready,
    input  che_pkg::t_sts              i_sts,
    output che_pkg::t_cmd              o_cmd
);
    import che_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_DECODE   = 10'b0000000010,
        S_HASH     = 10'b0000000100,
        S_INS_BKT  = 10'b0000001000,
        S_INS_LINK = 10'b0000010000,
        S_FND_BKT  = 10'b0000100000,
        S_FND_CHK  = 10'b0001000000,
        S_DEL_REC  = 10'b0010000000,
        S_DEL_BKT  = 10'b0100000000,
        S_EMIT     = 10'b1000000000
    } t_state;

    t_state   r_state, n_state;
    t_kind    r_kind, n_kind;
    t_out_sel r_emit, n_emit;
    t_cmd     cmd;
    logic     stop;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_emit  = r_emit;
        cmd     = '0;
        stop    = 1'b0;
        case (r_state)
            S_IDLE: begin
                // Take the item; the reserved kind is dropped
                if (i_s_valid && t_kind'(i_kind) != KIND_RSVD) begin
                    cmd.capture = 1'b1;
                    n_kind      = t_kind'(i_kind);
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                case (r_kind)
                    KIND_INSERT: begin
                        if (i_sts.too_long) begin
                            n_emit  = OS_LONG;
                            n_state = S_EMIT;
                        end else begin
                            cmd.hash_start = 1'b1;
                            cmd.scan_start = 1'b1;
                            n_state        = S_HASH;
                        end
                    end
                    KIND_FIND: begin
                        if (i_sts.find_skip) begin
                            n_emit  = OS_NO_MATCH;
                            n_state = S_EMIT;
                        end else begin
                            cmd.hash_start = 1'b1;
                            n_state        = S_HASH;
                        end
                    end
                    KIND_DELETE: begin
                        if (i_sts.del_invalid) begin
                            n_emit  = OS_BAD_HDL;
                            n_state = S_EMIT;
                        end else begin
                            cmd.ent_rd  = 1'b1;
                            cmd.ent_src = ENT_HANDLE;
                            n_state     = S_DEL_REC;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_HASH: begin
                if (i_sts.hash_done && !i_sts.scan_busy) begin
                    if (r_kind == KIND_INSERT && !i_sts.free_found) begin
                        n_emit  = OS_FULL;
                        n_state = S_EMIT;
                    end else begin
                        cmd.bkt_rd  = 1'b1;
                        cmd.bkt_src = BKT_HASH;
                        n_state     = (r_kind == KIND_INSERT) ? S_INS_BKT : S_FND_BKT;
                    end
                end
            end
            S_INS_BKT: begin
                cmd.ins_wr1 = 1'b1;
                n_state     = S_INS_LINK;
            end
            S_INS_LINK: begin
                cmd.ins_wr2 = 1'b1;
                n_emit      = OS_INS_OK;
                n_state     = S_EMIT;
            end
            S_FND_BKT: begin
                if (!i_sts.bkt_nonempty) begin
                    n_emit  = OS_NO_MATCH;
                    n_state = S_EMIT;
                end else begin
                    cmd.ent_rd  = 1'b1;
                    cmd.ent_src = ENT_HEAD;
                    n_state     = S_FND_CHK;
                end
            end
            S_FND_CHK: begin
                // Hold while an earlier match cannot move to the output yet
                if (!(i_sts.match && i_sts.pend_valid && !i_sts.out_free)) begin
                    if (i_sts.match) begin
                        cmd.fnd_take = 1'b1;
                        if (i_sts.pend_valid) begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = OS_PEND_MID;
                        end
                    end
                    stop = i_sts.is_tail || (i_sts.match && i_sts.hit_limit);
                    if (stop) begin
                        n_emit  = (i_sts.match || i_sts.pend_valid) ? OS_PEND_LAST
                                                                    : OS_NO_MATCH;
                        n_state = S_EMIT;
                    end else begin
                        cmd.ent_rd  = 1'b1;
                        cmd.ent_src = ENT_NEXT;
                    end
                end
            end
            S_DEL_REC: begin
                cmd.bkt_rd  = 1'b1;
                cmd.bkt_src = BKT_REC;
                n_state     = S_DEL_BKT;
            end
            S_DEL_BKT: begin
                cmd.del_wr = 1'b1;
                n_emit     = OS_DEL_OK;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = r_emit;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= KIND_INSERT;
            r_emit  <= OS_NO_MATCH;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_emit  <= n_emit;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_cmd     = cmd;

`ifndef ASSERT_OFF
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over an untaken result");
    a_insert_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ins_wr1 |-> i_sts.free_found)
        else $error("insert written without a free entry");
    a_delete_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.del_wr |-> !i_sts.del_invalid)
        else $error("delete of an entry that is not valid");
    a_link_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ins_wr1 |=> cmd.ins_wr2)
        else $error("insert link-up step skipped");
`endif

endmodule

>>> hw/rtl/chained_hash_table_engine.sv
// Top level of the chained hash table engine: stream ports, register port, units.
//
// A 64-entry hash table with bucket chains. One operation is handled at a
// time: s_axis_tready is high only while the engine waits for an item.
// An insert and a find both start with the hash unit, which adds up to
// four slices of the key and reduces the sum modulo the bucket count four
// bits per cycle; a find then visits the chain entries one at a time. A
// delete reads the entry and then, dependent on it, the bucket.
// Key-too-long, invalid handle and skipped finds go from decode straight
// to the result. Results pass through an output register, so the next
// item is taken while a result waits. Valid and nonempty marks are
// flip-flops cleared at reset; no clearing pass is needed.
module chained_hash_table_engine (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // key[63:0], key_length[67:64], data_value[99:68], handle[105:100],
    // max_matches[112:106], zero[119:113]
    input  logic [119:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]   s_axis_tuser,
    // Result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], handle_res[8:3], data_value_res[40:9], match_count[47:41]
    output logic [47:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    // Register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import che_pkg::*;

    localparam int REG_BUCKET_COUNT = 0;
    localparam int REG_MAX_KEY_LEN  = 1;

    logic [BC_W-1:0]   r_bucket_count;
    logic [LEN_W-1:0]  r_max_key_len;
    logic [BC_W-1:0]   eff_buckets;
    logic [LEN_W-1:0]  key_limit;
    logic              reg_sel;
    t_cmd              cmd;
    t_sts              sts;
    logic [STAT_W-1:0] status;

    // Register writes
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BC_W'(BUCKETS);
            r_max_key_len  <= LEN_W'(KEY_BYTES);
        end else if (psel && penable && pwrite) begin
            if (reg_sel == 1'(REG_BUCKET_COUNT)) begin
                r_bucket_count <= pwdata[BC_W-1:0];
            end else if (reg_sel == 1'(REG_MAX_KEY_LEN)) begin
                r_max_key_len <= pwdata[LEN_W-1:0];
            end
        end
    end

    assign prdata = (reg_sel == 1'(REG_MAX_KEY_LEN)) ? {{(32-LEN_W){1'b0}}, r_max_key_len}
                                                     : {{(32-BC_W){1'b0}}, r_bucket_count};
    assign pready = 1'b1;

    // Clamp the bucket count and key limit to what the table supports
    assign eff_buckets = (r_bucket_count == '0) ? BC_W'(1)
                       : (r_bucket_count > BC_W'(BUCKETS)) ? BC_W'(BUCKETS)
                       : r_bucket_count;
    assign key_limit   = (r_max_key_len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES)
                                                             : r_max_key_len;

    che_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_kind    (s_axis_tuser),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    che_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_key            (s_axis_tdata[63:0]),
        .i_key_length     (s_axis_tdata[67:64]),
        .i_data_value     (s_axis_tdata[99:68]),
        .i_handle         (s_axis_tdata[105:100]),
        .i_max_matches    (s_axis_tdata[112:106]),
        .i_bucket_count   (eff_buckets),
        .i_key_limit      (key_limit),
        .i_m_ready        (m_axis_tready),
        .o_m_valid        (m_axis_tvalid),
        .o_status         (status),
        .o_handle_res     (m_axis_tdata[8:3]),
        .o_data_value_res (m_axis_tdata[40:9]),
        .o_match_count    (m_axis_tdata[47:41]),
        .o_last           (m_axis_tlast)
    );

    assign m_axis_tdata[2:0] = status;

endmodule
